// ===== rtl/id3u_pkg.sv =====
// Types and constants shared by the ID3 text to UTF-8 transcoder.
`default_nettype none

package id3u_pkg;

  localparam int CAP_W   = 13;
  localparam int RES_MAX = 7;
  localparam int RES_CW  = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = 13'd256;

  localparam logic [15:0] SURR_HI_FIRST = 16'hD800;
  localparam logic [15:0] SURR_HI_LAST  = 16'hDBFF;
  localparam logic [15:0] SURR_LO_FIRST = 16'hDC00;
  localparam logic [15:0] SURR_LO_LAST  = 16'hDFFF;
  localparam logic [20:0] PLANE1_BASE   = 21'h10000;
  localparam logic [20:0] CP_1BYTE_END  = 21'h00080;
  localparam logic [20:0] CP_2BYTE_END  = 21'h00800;

  localparam logic [7:0] BOM_FF    = 8'hFF;
  localparam logic [7:0] BOM_FE    = 8'hFE;
  localparam logic [7:0] LEAD_2    = 8'hC0;
  localparam logic [7:0] LEAD_3    = 8'hE0;
  localparam logic [7:0] LEAD_4    = 8'hF0;
  localparam logic [7:0] CONT_MARK = 8'h80;
  localparam logic [7:0] TERM_BYTE = 8'h00;

  typedef enum logic [1:0] {
    ENC_LATIN1    = 2'd0,
    ENC_UTF16_BOM = 2'd1,
    ENC_UTF16_BE  = 2'd2,
    ENC_UTF8      = 2'd3
  } enc_t;

  typedef struct packed {
    enc_t       enc;
    logic [7:0] data;
    logic       present;
    logic       last;
  } item_t;

  typedef struct packed {
    enc_t       enc;
    logic       at_start;
    logic       unit_zero;
    logic       big_endian;
    logic [7:0] pend_byte;
    logic       pend_valid;
    logic [9:0] held_surr;
    logic       held_valid;
    logic       stopped;
  } state_t;

  typedef struct packed {
    logic [RES_MAX-1:0][7:0] data;
    logic [RES_CW-1:0]       cnt;
    logic                    fin;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/id3u_dec.sv =====
// Decode of one string byte against the string state into up to seven UTF-8 bytes.
`default_nettype none

module id3u_dec
  import id3u_pkg::*;
#(
  parameter int LW = 13
) (
  input  wire state_t          st,
  input  wire logic [LW-1:0]   bw,
  input  wire logic [LW-1:0]   lim,
  input  wire item_t           item,
  output state_t               st_next,
  output logic [LW-1:0]        bw_next,
  output res_t                 res
);

  localparam int LW1 = LW + 1;

  typedef struct packed {
    logic          ok;
    logic [LW-1:0] bw;
    res_t          r;
  } emit_t;

  function automatic logic [2:0] cp_len(logic [20:0] cp);
    if (cp < CP_1BYTE_END) begin
      return 3'd1;
    end else if (cp < CP_2BYTE_END) begin
      return 3'd2;
    end else if (cp < PLANE1_BASE) begin
      return 3'd3;
    end
    return 3'd4;
  endfunction

  function automatic logic [3:0][7:0] cp_bytes(logic [20:0] cp);
    logic [3:0][7:0] bb;
    bb = '0;
    case (cp_len(cp))
      3'd1: begin
        bb[0] = cp[7:0];
      end
      3'd2: begin
        bb[0] = LEAD_2 | {3'b0, cp[10:6]};
        bb[1] = CONT_MARK | {2'b0, cp[5:0]};
      end
      3'd3: begin
        bb[0] = LEAD_3 | {4'b0, cp[15:12]};
        bb[1] = CONT_MARK | {2'b0, cp[11:6]};
        bb[2] = CONT_MARK | {2'b0, cp[5:0]};
      end
      default: begin
        bb[0] = LEAD_4 | {5'b0, cp[20:18]};
        bb[1] = CONT_MARK | {2'b0, cp[17:12]};
        bb[2] = CONT_MARK | {2'b0, cp[11:6]};
        bb[3] = CONT_MARK | {2'b0, cp[5:0]};
      end
    endcase
    return bb;
  endfunction

  function automatic res_t push(res_t r, logic [7:0] b);
    res_t o;
    o = r;
    o.data[o.cnt] = b;
    o.cnt = o.cnt + 3'd1;
    return o;
  endfunction

  function automatic emit_t try_emit(res_t r, logic [LW-1:0] w, logic [LW-1:0] lm,
                                     logic [20:0] cp);
    emit_t           e;
    logic [2:0]      n;
    logic [3:0][7:0] bb;
    logic [LW1-1:0]  need;
    n    = cp_len(cp);
    bb   = cp_bytes(cp);
    need = {1'b0, w} + LW1'(n);
    e.r  = r;
    e.bw = w;
    e.ok = (need <= {1'b0, lm});
    if (e.ok) begin
      for (int i = 0; i < 4; i++) begin
        if (3'(i) < n) begin
          e.r = push(e.r, bb[i]);
        end
      end
      e.bw = need[LW-1:0];
    end
    return e;
  endfunction

  state_t        s;
  logic [LW-1:0] w;
  res_t          r;
  emit_t         em;
  logic          fin;
  logic          skip;
  logic          done;
  logic [15:0]   u;
  logic [20:0]   join_cp;

  always_comb begin
    s       = st;
    w       = bw;
    r       = '0;
    em      = '0;
    fin     = 1'b0;
    skip    = 1'b0;
    done    = 1'b0;
    u       = '0;
    join_cp = '0;

    if (s.at_start) begin
      s.enc        = item.enc;
      s.at_start   = 1'b0;
      s.unit_zero  = 1'b1;
      s.big_endian = (item.enc == ENC_UTF16_BE);
      s.pend_byte  = '0;
      s.pend_valid = 1'b0;
      s.held_surr  = '0;
      s.held_valid = 1'b0;
      s.stopped    = 1'b0;
      w            = '0;
    end

    if (!s.stopped && item.present) begin
      case (s.enc)
        ENC_UTF8: begin
          if (w >= lim || item.data == TERM_BYTE) begin
            fin = 1'b1;
          end else begin
            r = push(r, item.data);
            w = w + LW'(1);
          end
        end
        ENC_LATIN1: begin
          if (item.data == TERM_BYTE) begin
            fin = 1'b1;
          end else begin
            em  = try_emit(r, w, lim, {13'b0, item.data});
            r   = em.r;
            w   = em.bw;
            fin = !em.ok;
          end
        end
        default: begin
          if (!s.pend_valid) begin
            s.pend_byte  = item.data;
            s.pend_valid = 1'b1;
          end else begin
            s.pend_valid = 1'b0;
            if (s.unit_zero) begin
              s.unit_zero = 1'b0;
              if (s.enc == ENC_UTF16_BOM) begin
                if (s.pend_byte == BOM_FF && item.data == BOM_FE) begin
                  s.big_endian = 1'b0;
                  skip         = 1'b1;
                end else if (s.pend_byte == BOM_FE && item.data == BOM_FF) begin
                  s.big_endian = 1'b1;
                  skip         = 1'b1;
                end
              end
            end
            u = s.big_endian ? {s.pend_byte, item.data} : {item.data, s.pend_byte};
            if (!skip) begin
              if (s.held_valid) begin
                s.held_valid = 1'b0;
                if (u >= SURR_LO_FIRST && u <= SURR_LO_LAST) begin
                  join_cp = PLANE1_BASE + {1'b0, s.held_surr, 10'b0}
                          + {11'b0, u[9:0]};
                  em   = try_emit(r, w, lim, join_cp);
                  r    = em.r;
                  w    = em.bw;
                  fin  = !em.ok;
                  done = 1'b1;
                end else begin
                  em  = try_emit(r, w, lim, {5'b0, SURR_HI_FIRST[15:10], s.held_surr});
                  r   = em.r;
                  w   = em.bw;
                  fin = !em.ok;
                  done = !em.ok;
                end
              end
              if (!done) begin
                if (u == 16'h0000) begin
                  fin = 1'b1;
                end else if (u >= SURR_HI_FIRST && u <= SURR_HI_LAST) begin
                  s.held_surr  = u[9:0];
                  s.held_valid = 1'b1;
                end else begin
                  em  = try_emit(r, w, lim, {5'b0, u});
                  r   = em.r;
                  w   = em.bw;
                  fin = !em.ok;
                end
              end
            end
          end
        end
      endcase
    end

    if (item.last && !s.stopped && !fin) begin
      if (s.held_valid) begin
        em = try_emit(r, w, lim, {5'b0, SURR_HI_FIRST[15:10], s.held_surr});
        r  = em.r;
        w  = em.bw;
      end
      fin = 1'b1;
    end

    if (fin) begin
      s.stopped    = 1'b1;
      s.held_valid = 1'b0;
      s.pend_valid = 1'b0;
      r            = push(r, TERM_BYTE);
      r.fin        = 1'b1;
    end

    if (item.last) begin
      s.at_start = 1'b1;
    end

    st_next = s;
    bw_next = w;
    res     = r;
  end

endmodule

`default_nettype wire

// ===== rtl/id3_text_to_utf8_transcoder_unit.sv =====
// Top level of the ID3 text to UTF-8 transcoder: item register, decode, result buffer.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_stall  text_encoding, data_byte, byte_present, last_byte
//   out      source     out_valid/out_stall  out_byte, end_of_string
//   cfg      sink       cfg_valid/cfg_ready  capacity
//
// An item waits in the item register; the result buffer is then loaded from it, and its
// results (zero to seven bytes) go out one per cycle while out_stall is low.
// An item that gives at most one result leaves room for the next item every cycle that
// out_stall is low; one that gives more holds the result buffer until its last is taken.
// Reset (rst, synchronous) clears the string state and sets the capacity to 256.
// A stalled result holds the buffer and, once the item register is full, stalls input.
`default_nettype none

module id3_text_to_utf8_transcoder_unit
  import id3u_pkg::*;
#(
  parameter int MAX_CAPACITY = 4096
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [1:0]       text_encoding,
  input  wire logic [7:0]       data_byte,
  input  wire logic             byte_present,
  input  wire logic             last_byte,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [7:0]            out_byte,
  output logic                  end_of_string,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CAP_W-1:0] capacity
);

  localparam int CW = $clog2(MAX_CAPACITY + 1);
  localparam int LW = (CW > CAP_W) ? CW : CAP_W;
  localparam logic [LW-1:0] MAX_CAP = LW'(MAX_CAPACITY);

  function automatic logic [LW-1:0] limit_of(logic [CAP_W-1:0] cap);
    logic [LW-1:0] c;
    c = LW'(cap);
    if (c == '0) begin
      c = LW'(1);
    end else if (c > MAX_CAP) begin
      c = MAX_CAP;
    end
    return c - LW'(1);
  endfunction

  logic [LW-1:0] limit;

  logic          in_full;
  item_t         item;

  state_t        st;
  state_t        st_next;
  logic [LW-1:0] bw;
  logic [LW-1:0] bw_next;
  res_t          res;

  logic                    busy;
  logic [RES_MAX-1:0][7:0] ob_data;
  logic [RES_CW-1:0]       ob_cnt;
  logic [RES_CW-1:0]       ob_idx;
  logic                    ob_fin;

  logic ob_last;
  logic take;
  logic load_ok;
  logic adv;
  logic in_acc;

  assign cfg_ready = 1'b1;

  assign ob_last  = (ob_idx == ob_cnt - 3'd1);
  assign take     = busy && !out_stall;
  assign load_ok  = !busy || (take && ob_last);
  assign adv      = in_full && load_ok;
  assign in_stall = in_full && !adv;
  assign in_acc   = in_valid && !in_stall;

  assign out_valid     = busy;
  assign out_byte      = ob_data[ob_idx];
  assign end_of_string = ob_fin && ob_last;

  id3u_dec #(
    .LW (LW)
  ) u_dec (
    .st      (st),
    .bw      (bw),
    .lim     (limit),
    .item    (item),
    .st_next (st_next),
    .bw_next (bw_next),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= limit_of(CAP_RESET);
    end else if (cfg_valid && cfg_ready) begin
      limit <= limit_of(capacity);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_acc) begin
      in_full <= 1'b1;
    end else if (adv) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item <= '{enc: enc_t'(text_encoding), data: data_byte, present: byte_present,
                last: last_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{enc: ENC_LATIN1, at_start: 1'b1, unit_zero: 1'b1, big_endian: 1'b0,
              pend_byte: 8'h00, pend_valid: 1'b0, held_surr: 10'h000, held_valid: 1'b0,
              stopped: 1'b0};
      bw <= '0;
    end else if (adv) begin
      st <= st_next;
      bw <= bw_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      ob_idx <= '0;
    end else if (adv) begin
      busy   <= (res.cnt != '0);
      ob_idx <= '0;
    end else if (take) begin
      if (ob_last) begin
        busy <= 1'b0;
      end else begin
        ob_idx <= ob_idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ob_data <= res.data;
      ob_cnt  <= res.cnt;
      ob_fin  <= res.fin;
    end
  end

`ifndef SYNTH
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (ob_idx < ob_cnt))
    else $error("result index beyond result count");

  a_load_restarts: assert property (@(posedge clk) disable iff (rst)
    (adv && res.cnt != '0) |=> (busy && ob_idx == '0))
    else $error("result buffer not loaded from the start");

  a_stop_clears: assert property (@(posedge clk) disable iff (rst)
    st.stopped |-> (!st.held_valid && !st.pend_valid))
    else $error("held data left after the string stopped");

  a_eos_last: assert property (@(posedge clk) disable iff (rst)
    (take && end_of_string) |=> (!busy || ob_idx == '0))
    else $error("result left after the terminator");
`endif

endmodule

`default_nettype wire
